// ===== rtl/double_pulse_test_sequencer_assert.svh =====
// Assertion macros used by the sequencer RTL.
`ifndef DOUBLE_PULSE_TEST_SEQUENCER_ASSERT_SVH
`define DOUBLE_PULSE_TEST_SEQUENCER_ASSERT_SVH

// Checked at every clock edge outside reset.
`define DPTS_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define DPTS_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ===== rtl/dpts_pkg.sv =====
`timescale 1ns / 1ps

package dpts_pkg;

    localparam int ELAPSED_WIDTH  = 32;
    localparam int INTERVAL_WIDTH = 16;
    localparam int CURRENT_WIDTH  = 16;

    // Widths of the fields and registers as seen on the ports.
    localparam int SAMPLE_FIELD_W  = 16;
    localparam int TIMEOUT_FIELD_W = 32;
    localparam int TICKS_FIELD_W   = 16;
    localparam int CFG_DATA_W      = 32;
    localparam int CFG_INDEX_W     = 3;
    localparam int OUT_TDATA_W     = 8;

    // Compare widths wide enough for both operands.
    localparam int ELAPSED_CMP_W  = (ELAPSED_WIDTH > TIMEOUT_FIELD_W) ?
                                    ELAPSED_WIDTH : TIMEOUT_FIELD_W;
    localparam int INTERVAL_CMP_W = (INTERVAL_WIDTH > TICKS_FIELD_W) ?
                                    INTERVAL_WIDTH : TICKS_FIELD_W;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_ARM    = 2'd2,
        OP_ABORT  = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_CHARGING = 3'd1,
        PH_DEADTIME = 3'd2,
        PH_PULSE2   = 3'd3,
        PH_DONE     = 3'd4,
        PH_FAULT    = 3'd5
    } t_phase;

    localparam logic [CFG_INDEX_W-1:0] REG_LIMIT_CURRENT   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GOAL_CURRENT    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CHARGE_TIMEOUT  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_GAP_TICKS       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SECOND_PULSE    = 3'd4;

    // A 16-bit field taken as a two's complement number of CURRENT_WIDTH bits:
    // narrower widths keep the low bits, wider ones zero-extend.
    function automatic logic signed [CURRENT_WIDTH-1:0] to_current(
        input logic [SAMPLE_FIELD_W-1:0] v
    );
        logic [63:0] ext;
        ext = {{(64-SAMPLE_FIELD_W){1'b0}}, v};
        return $signed(ext[CURRENT_WIDTH-1:0]);
    endfunction

endpackage

// ===== rtl/double_pulse_test_sequencer.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake               Payload
// s_axis    in         i_s_tvalid/o_s_tready   tuser: opcode; tdata: current_sample
// m_axis    out        o_m_tvalid/i_m_tready   tdata: switch_on, phase
// cfg       in         i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// One request per clock cycle; its result is visible in the cycle after acceptance.
// The sequencer state registers double as the result register, so a new request
// is taken whenever no result is pending or the pending one is being taken.
// A stalled result holds the input side off until it is consumed.
// Synchronous active-low reset returns to idle with the switch off and the
// configuration registers at their defaults.

`include "double_pulse_test_sequencer_assert.svh"

module double_pulse_test_sequencer (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // Input stream.
    input  logic                                    i_s_tvalid,
    output logic                                    o_s_tready,
    input  logic [dpts_pkg::SAMPLE_FIELD_W-1:0]     i_s_tdata,   // [15:0] current_sample
    input  logic [1:0]                              i_s_tuser,   // [1:0] opcode
    // Result stream.
    output logic                                    o_m_tvalid,
    input  logic                                    i_m_tready,
    output logic [dpts_pkg::OUT_TDATA_W-1:0]        o_m_tdata,   // [0] switch_on, [3:1] phase
    // Configuration writes.
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [dpts_pkg::CFG_INDEX_W-1:0]        i_cfg_index,
    input  logic [dpts_pkg::CFG_DATA_W-1:0]         i_cfg_data
);
    import dpts_pkg::*;

    localparam logic [ELAPSED_WIDTH-1:0]  ELAPSED_MAX  = '1;
    localparam logic [INTERVAL_WIDTH-1:0] INTERVAL_MAX = '1;

    logic [SAMPLE_FIELD_W-1:0]  r_limit_current;
    logic [SAMPLE_FIELD_W-1:0]  r_goal_current;
    logic [TIMEOUT_FIELD_W-1:0] r_charge_timeout;
    logic [TICKS_FIELD_W-1:0]   r_gap_ticks;
    logic [TICKS_FIELD_W-1:0]   r_second_pulse;

    t_phase                     r_phase, n_phase;
    logic                       r_drive, n_drive;
    logic [ELAPSED_WIDTH-1:0]   r_elapsed, n_elapsed;
    logic [INTERVAL_WIDTH-1:0]  r_interval, n_interval;
    logic                       r_out_valid;

    logic                       in_acc;
    t_opcode                    op;
    logic signed [CURRENT_WIDTH-1:0] sample, lim, goal;
    logic [INTERVAL_WIDTH-1:0]  interval_inc;
    logic [INTERVAL_CMP_W-1:0]  interval_target;
    logic                       interval_end;
    logic                       timed_out;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !r_out_valid || i_m_tready;
    assign in_acc      = i_s_tvalid && o_s_tready;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {{(OUT_TDATA_W-4){1'b0}}, r_phase, r_drive};

    assign op     = t_opcode'(i_s_tuser);
    assign sample = to_current(i_s_tdata);
    assign lim    = to_current(r_limit_current);
    assign goal   = to_current(r_goal_current);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit_current  <= 16'h7FFF;
            r_goal_current   <= '0;
            r_charge_timeout <= '1;
            r_gap_ticks      <= '0;
            r_second_pulse   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_LIMIT_CURRENT:  r_limit_current  <= i_cfg_data[SAMPLE_FIELD_W-1:0];
                REG_GOAL_CURRENT:   r_goal_current   <= i_cfg_data[SAMPLE_FIELD_W-1:0];
                REG_CHARGE_TIMEOUT: r_charge_timeout <= i_cfg_data[TIMEOUT_FIELD_W-1:0];
                REG_GAP_TICKS:      r_gap_ticks      <= i_cfg_data[TICKS_FIELD_W-1:0];
                REG_SECOND_PULSE:   r_second_pulse   <= i_cfg_data[TICKS_FIELD_W-1:0];
                default: ;
            endcase
        end
    end

    // The interval counter saturates; an interval ends on reaching its target
    // or the counter's maximum.
    assign interval_inc    = (r_interval != INTERVAL_MAX) ? r_interval + 1'b1 : r_interval;
    assign interval_target = (r_phase == PH_DEADTIME) ?
                             INTERVAL_CMP_W'(r_gap_ticks) : INTERVAL_CMP_W'(r_second_pulse);
    assign interval_end    = (INTERVAL_CMP_W'(interval_inc) >= interval_target) ||
                             (interval_inc == INTERVAL_MAX);
    assign timed_out       = ELAPSED_CMP_W'(r_elapsed) >= ELAPSED_CMP_W'(r_charge_timeout);

    always_comb begin
        n_phase    = r_phase;
        n_drive    = r_drive;
        n_elapsed  = r_elapsed;
        n_interval = r_interval;
        unique case (op)
            OP_TICK: begin
                if (r_phase == PH_CHARGING) begin
                    if (r_elapsed != ELAPSED_MAX) n_elapsed = r_elapsed + 1'b1;
                end else if (r_phase == PH_DEADTIME || r_phase == PH_PULSE2) begin
                    n_interval = interval_end ? '0 : interval_inc;
                    if (interval_end) begin
                        n_drive = (r_phase == PH_DEADTIME);
                        n_phase = (r_phase == PH_DEADTIME) ? PH_PULSE2 : PH_DONE;
                    end
                end
            end
            OP_SAMPLE: begin
                if (r_phase == PH_CHARGING) begin
                    priority if (sample >= lim || timed_out) begin
                        n_drive = 1'b0;
                        n_phase = PH_FAULT;
                    end else if (sample >= goal) begin
                        n_drive    = 1'b0;
                        n_phase    = PH_DEADTIME;
                        n_interval = '0;
                    end
                end
            end
            OP_ARM: begin
                if (goal < lim) begin
                    n_drive    = 1'b1;
                    n_phase    = PH_CHARGING;
                    n_elapsed  = '0;
                    n_interval = '0;
                end
            end
            OP_ABORT: begin
                n_drive    = 1'b0;
                n_phase    = PH_IDLE;
                n_elapsed  = '0;
                n_interval = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_drive     <= 1'b0;
            r_elapsed   <= '0;
            r_interval  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_phase    <= n_phase;
                r_drive    <= n_drive;
                r_elapsed  <= n_elapsed;
                r_interval <= n_interval;
            end
            if (in_acc) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The switch conducts exactly in the two on-pulse phases.
    `DPTS_ASSERT(a_drive_phase, r_drive == (r_phase == PH_CHARGING || r_phase == PH_PULSE2), "switch drive disagrees with phase")
    // The interval counter only runs while a timed interval is in progress.
    `DPTS_ASSERT(a_interval_idle, (r_phase == PH_DEADTIME || r_phase == PH_PULSE2) || r_interval == '0, "interval counter left running")
    `DPTS_ASSERT(a_abort_idle, in_acc && op == OP_ABORT |=> r_phase == PH_IDLE && !r_drive && r_elapsed == '0, "abort did not return to idle")
    `DPTS_ASSERT_ALWAYS(a_result_follows, i_rst_n && in_acc |=> r_out_valid, "accepted request produced no result")

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import dpts_pkg::*;

    localparam int WATCHDOG_LIMIT   = 5000;
    localparam int SEGMENTS         = 12;
    localparam int SEGMENT_REQUESTS = 26;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

    typedef enum int {
        IDLE_RECEIVER_SLOW,
        IDLE_SENDER_SLOW,
        IDLE_NONE
    } t_idle_mode;

    typedef enum int {
        SAMPLE_BELOW_GOAL,
        SAMPLE_REACHES_GOAL,
        SAMPLE_OVER_LIMIT,
        SAMPLE_ANY
    } t_sample_kind;

    typedef struct packed {
        t_opcode                   op;
        logic [SAMPLE_FIELD_W-1:0] current;
    } t_sequencer_request;

    typedef struct packed {
        logic   switch_on;
        t_phase phase;
    } t_sequencer_result;

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_s_tvalid  = 1'b0;
    logic                      o_s_tready;
    logic [SAMPLE_FIELD_W-1:0] i_s_tdata   = '0;   // [15:0] current_sample
    logic [1:0]                i_s_tuser   = OP_TICK;  // [1:0] opcode
    logic                      o_m_tvalid;
    logic                      i_m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0]    o_m_tdata;          // [0] switch_on, [3:1] phase
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_INDEX_W-1:0]    i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]     i_cfg_data  = '0;

    double_pulse_test_sequencer u_dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    t_sequencer_request pending_requests[$];
    t_sequencer_result  expected_results[$];
    t_sequencer_request in_flight;
    t_idle_mode         idle_mode = IDLE_RECEIVER_SLOW;
    int                 total_pushed = 0;
    int                 fail_count = 0;
    int                 quiet_cycles = 0;

    // Predicted sequencer state and register copies.
    t_phase                      seq_phase      = PH_IDLE;
    logic [ELAPSED_WIDTH-1:0]    charge_ticks   = '0;
    logic [INTERVAL_WIDTH-1:0]   interval_ticks = '0;
    logic                        drive_on       = 1'b0;
    logic signed [15:0]          limit_cfg      = 16'sh7FFF;
    logic signed [15:0]          goal_cfg       = '0;
    logic [TIMEOUT_FIELD_W-1:0]  timeout_cfg    = '1;
    logic [TICKS_FIELD_W-1:0]    gap_cfg        = '0;
    logic [TICKS_FIELD_W-1:0]    pulse2_cfg     = '0;

    // A programmed length of zero still takes one tick.
    function automatic bit interval_expired(input logic [TICKS_FIELD_W-1:0] target);
        if (interval_ticks != '1)
            interval_ticks++;
        if (interval_ticks >= target || interval_ticks == '1) begin
            interval_ticks = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void advance_sequencer(input t_sequencer_request req);
        t_sequencer_result res;
        case (req.op)
            OP_TICK: begin
                if (seq_phase == PH_CHARGING) begin
                    if (charge_ticks != '1)
                        charge_ticks++;
                end else if (seq_phase == PH_DEADTIME) begin
                    if (interval_expired(gap_cfg)) begin
                        drive_on  = 1'b1;
                        seq_phase = PH_PULSE2;
                    end
                end else if (seq_phase == PH_PULSE2) begin
                    if (interval_expired(pulse2_cfg)) begin
                        drive_on  = 1'b0;
                        seq_phase = PH_DONE;
                    end
                end
            end
            OP_SAMPLE: begin
                if (seq_phase == PH_CHARGING) begin
                    if ($signed(req.current) >= limit_cfg || charge_ticks >= timeout_cfg) begin
                        drive_on  = 1'b0;
                        seq_phase = PH_FAULT;
                    end else if ($signed(req.current) >= goal_cfg) begin
                        drive_on       = 1'b0;
                        seq_phase      = PH_DEADTIME;
                        interval_ticks = '0;
                    end
                end
            end
            OP_ARM: begin
                if (goal_cfg < limit_cfg) begin
                    drive_on       = 1'b1;
                    seq_phase      = PH_CHARGING;
                    charge_ticks   = '0;
                    interval_ticks = '0;
                end
            end
            OP_ABORT: begin
                drive_on       = 1'b0;
                seq_phase      = PH_IDLE;
                charge_ticks   = '0;
                interval_ticks = '0;
            end
        endcase
        res.switch_on = drive_on;
        res.phase     = seq_phase;
        expected_results.push_back(res);
    endfunction

    function automatic bit sender_pauses();
        case (idle_mode)
            IDLE_RECEIVER_SLOW: return $urandom_range(99) < 12;
            IDLE_SENDER_SLOW:   return $urandom_range(99) < 81;
            default:            return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_ready();
        case (idle_mode)
            IDLE_RECEIVER_SLOW: return $urandom_range(99) >= 81;
            IDLE_SENDER_SLOW:   return $urandom_range(99) >= 12;
            default:            return 1'b1;
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready)
                advance_sequencer(in_flight);
            if (!i_s_tvalid || o_s_tready) begin
                if (pending_requests.size() != 0 && !sender_pauses()) begin
                    in_flight = pending_requests.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tuser  <= in_flight.op;
                    i_s_tdata  <= in_flight.current;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_sequencer_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_results.size() == 0) begin
                $error("result 0x%h arrived with no request outstanding", o_m_tdata);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_m_tdata[0] !== want.switch_on) begin
                    $error("switch_on: expected %0d, actual %0d", want.switch_on, o_m_tdata[0]);
                    fail_count++;
                end
                if (o_m_tdata[3:1] !== want.phase) begin
                    $error("phase: expected %0d, actual %0d", want.phase, o_m_tdata[3:1]);
                    fail_count++;
                end
            end
        end
        i_m_tready <= receiver_ready();
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic int rand_between(input int lo, input int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic int pick_sample(input t_sample_kind kind);
        int lo;
        int hi;
        lo = -32768;
        hi = 32767;
        case (kind)
            SAMPLE_BELOW_GOAL:   hi = int'(goal_cfg) - 1;
            SAMPLE_REACHES_GOAL: begin
                lo = int'(goal_cfg);
                hi = int'(limit_cfg) - 1;
            end
            SAMPLE_OVER_LIMIT:   lo = int'(limit_cfg);
            default: ;
        endcase
        if (hi < lo) begin
            lo = -32768;
            hi = 32767;
        end
        return rand_between(lo, hi);
    endfunction

    task automatic push_request(input t_opcode op, input int current);
        t_sequencer_request req;
        req.op      = op;
        req.current = 16'(current);
        pending_requests.push_back(req);
        total_pushed++;
    endtask

    // The data field is ignored for these requests, so it carries noise.
    task automatic push_control(input t_opcode op);
        push_request(op, $urandom);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_requests.size() != 0 || i_s_tvalid || expected_results.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (index)
            REG_LIMIT_CURRENT:  limit_cfg   = data[15:0];
            REG_GOAL_CURRENT:   goal_cfg    = data[15:0];
            REG_CHARGE_TIMEOUT: timeout_cfg = data;
            REG_GAP_TICKS:      gap_cfg     = data[15:0];
            REG_SECOND_PULSE:   pulse2_cfg  = data[15:0];
            default: ;
        endcase
    endtask

    // Upper bits of the narrow registers get noise; the block must drop them.
    task automatic configure(input int lim, input int goal,
                             input logic [TIMEOUT_FIELD_W-1:0] timeout,
                             input int gap, input int pulse2);
        repeat (2) @(posedge i_clk);
        write_reg(REG_LIMIT_CURRENT, {16'($urandom), 16'(lim)});
        write_reg(REG_GOAL_CURRENT, {16'($urandom), 16'(goal)});
        write_reg(REG_CHARGE_TIMEOUT, timeout);
        write_reg(REG_GAP_TICKS, {16'($urandom), 16'(gap)});
        write_reg(REG_SECOND_PULSE, {16'($urandom), 16'(pulse2)});
        @(negedge i_clk);
    endtask

    function automatic int pick_interval();
        if ($urandom_range(9) == 0)
            return $urandom_range(16'hFFFF);
        return $urandom_range(5);
    endfunction

    task automatic random_configure();
        int lim;
        int goal;
        logic [TIMEOUT_FIELD_W-1:0] timeout;
        case ($urandom_range(5))
            0: begin
                lim  = rand_between(-32768, 32767);
                goal = rand_between(-32768, 32767);
            end
            1: begin
                lim  = 32767;
                goal = -32768;
            end
            default: begin
                lim  = rand_between(-32000, 32767);
                goal = rand_between(-32768, lim - 1);
            end
        endcase
        case ($urandom_range(3))
            0:       timeout = '1;
            1:       timeout = '0;
            default: timeout = $urandom_range(15);
        endcase
        configure(lim, goal, timeout, pick_interval(), pick_interval());
    endtask

    // Mostly a full test cycle: arm, charge, reach the goal, then tick through
    // both intervals. Some runs are cut short or are plain noise.
    task automatic push_sequence();
        int ticks;
        t_sample_kind last_kind;
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(4, 1))
                push_request(t_opcode'($urandom_range(3)), $urandom);
            return;
        end
        push_control(OP_ARM);
        repeat ($urandom_range(2)) begin
            repeat ($urandom_range(3))
                push_control(OP_TICK);
            push_request(OP_SAMPLE, pick_sample(SAMPLE_BELOW_GOAL));
        end
        repeat ($urandom_range(4))
            push_control(OP_TICK);
        if ($urandom_range(11) == 0) begin
            push_control($urandom_range(1) ? OP_ARM : OP_ABORT);
            return;
        end
        case ($urandom_range(7))
            0:       last_kind = SAMPLE_OVER_LIMIT;
            1:       last_kind = SAMPLE_ANY;
            default: last_kind = SAMPLE_REACHES_GOAL;
        endcase
        push_request(OP_SAMPLE, pick_sample(last_kind));
        if (gap_cfg <= 8 && pulse2_cfg <= 8)
            ticks = (gap_cfg == 0 ? 1 : gap_cfg) + (pulse2_cfg == 0 ? 1 : pulse2_cfg) +
                    $urandom_range(2);
        else
            ticks = $urandom_range(6);
        repeat (ticks) begin
            if ($urandom_range(7) == 0)
                push_request(OP_SAMPLE, pick_sample(SAMPLE_ANY));
            push_control(OP_TICK);
        end
        if ($urandom_range(3) == 0)
            push_control(OP_ABORT);
    endtask

    initial begin : stimulus
        int seg;
        int first;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Default registers: one full cycle, then a fault by overcurrent.
        push_control(OP_TICK);
        push_request(OP_SAMPLE, 32767);
        push_control(OP_ARM);
        push_control(OP_TICK);
        push_request(OP_SAMPLE, -1);
        push_request(OP_SAMPLE, 0);
        push_control(OP_TICK);
        push_control(OP_TICK);
        push_control(OP_TICK);
        push_request(OP_SAMPLE, -32768);
        push_control(OP_ARM);
        push_request(OP_SAMPLE, 32767);
        push_control(OP_ABORT);
        wait_drained();

        // Goal equal to the limit: arm must be ignored.
        configure(-32768, -32768, '1, 0, 0);
        write_reg(REG_UNUSED, $urandom);
        @(negedge i_clk);
        push_control(OP_ARM);
        push_control(OP_TICK);
        wait_drained();

        // Zero timeout: any sample below the limit faults.
        configure(32767, -32768, '0, 1, 1);
        push_control(OP_ARM);
        push_request(OP_SAMPLE, 100);
        wait_drained();

        // Re-arm while charging clears the charge time.
        configure(1000, -5, 2, 1, 2);
        push_control(OP_ARM);
        push_control(OP_TICK);
        push_control(OP_TICK);
        push_control(OP_ARM);
        push_control(OP_TICK);
        push_request(OP_SAMPLE, 0);
        push_control(OP_TICK);
        push_control(OP_TICK);
        push_control(OP_TICK);
        push_control(OP_ABORT);

        for (seg = 0; seg < SEGMENTS; seg++) begin
            wait_drained();
            idle_mode = t_idle_mode'(seg * 3 / SEGMENTS);
            random_configure();
            first = total_pushed;
            while (total_pushed - first < SEGMENT_REQUESTS)
                push_sequence();
        end

        // Longest dead time and second pulse: a few ticks in, then abort.
        wait_drained();
        configure(32767, 0, '1, 16'hFFFF, 16'hFFFF);
        push_control(OP_ARM);
        push_request(OP_SAMPLE, 1);
        repeat (4)
            push_control(OP_TICK);
        push_control(OP_ABORT);

        wait_drained();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
